[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the quadrature decoder modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked while reset is low
`define QD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define QD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QD_ASSERT(lbl, clk, rst, prop, msg)
`define QD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[design/qdec_pkg.sv]
// ----------------------------------------------------------------------------
// qdec_pkg
// shared types, register codes and the x4 step table of the quadrature decoder
// ----------------------------------------------------------------------------
package qdec_pkg;

  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int TOGGLE_WIDTH_DEF = 16;

  localparam int POS_WIDTH = 32;
  localparam int IDX_WIDTH = 2;
  localparam int CFG_WIDTH = 16;

  // register indexes
  localparam logic [IDX_WIDTH-1:0] REG_ERROR_LIMIT  = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_CHECK_WINDOW = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_MIN_TOGGLES  = 2'd2;

  // register reset values
  localparam logic [7:0]  ERROR_LIMIT_RST  = 8'd10;
  localparam logic [15:0] CHECK_WINDOW_RST = 16'd360;
  localparam logic [15:0] MIN_TOGGLES_RST  = 16'd4;

  // direction codes, two bit signed
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_FWD,
    STEP_REV,
    STEP_BAD
  } step_t;

  typedef enum logic [1:0] {
    FAULT_OK,
    FAULT_INVALID,
    FAULT_A_DEAD,
    FAULT_B_DEAD
  } fault_t;

  typedef struct packed {
    logic [7:0]  error_limit;
    logic [15:0] check_window;
    logic [15:0] min_toggles;
  } cfg_t;

  typedef struct packed {
    logic [POS_WIDTH-1:0] position;
    logic [1:0]           moving_dir;
    logic                 fault_flag;
    fault_t               fault_kind;
  } result_t;

  // x4 gray code step for old pair to new pair, pair = {a, b}
  function automatic step_t step_lookup(input logic [1:0] old_ab, input logic [1:0] new_ab);
    step_t s;
    case ({old_ab, new_ab})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_REV;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_FWD;
      4'b0011, 4'b0110, 4'b1001, 4'b1100: s = STEP_BAD;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

[design/quadrature_decoder_with_fault_check.sv]
// ----------------------------------------------------------------------------
// quadrature_decoder_with_fault_check
// x4 quadrature decoder with invalid-transition and dead-phase supervision
// ----------------------------------------------------------------------------
// One sample of phases A and B is taken per transfer on the slave stream, and
// every sample yields exactly one result on the master stream: the wrapped
// pulse count, the last valid direction and the current fault state, all as
// seen after that sample. The block takes one sample per clock while it is
// ready; the decode, counter updates and health check are a single level
// of logic from the decoder state registers, so the result is registered
// at its sample transfer. A one-entry skid stage behind the output register
// keeps the slave side open while a finished result waits, so a stall on
// the master side backs up the input only once two results are queued. The
// first sample after reset is compared against an AB pair of 00.
// Configuration writes are taken at any time (cfg_ready is tied high) and
// are meant to be made while the stream is idle; index 3 is ignored.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_fault_check import qdec_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,   // pulse counter width, wraps
  parameter int TOGGLE_WIDTH = TOGGLE_WIDTH_DEF   // per-phase toggle counter width
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] phase_a, [1] phase_b, rest zero
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,   // [31:0] position, [33:32] moving_dir,
                                               // [34] fault_flag, [36:35] fault_kind
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_t    cfg;
  logic    in_xfer;
  logic    space;
  result_t step_res;
  result_t out_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_limit  <= ERROR_LIMIT_RST;
      cfg.check_window <= CHECK_WINDOW_RST;
      cfg.min_toggles  <= MIN_TOGGLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ERROR_LIMIT:  cfg.error_limit  <= cfg_data[7:0];
        REG_CHECK_WINDOW: cfg.check_window <= cfg_data;
        REG_MIN_TOGGLES:  cfg.min_toggles  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a sample is taken whenever the output side has a free slot
  assign s_axis_tready = space;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  qdec_step #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .TOGGLE_WIDTH (TOGGLE_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (in_xfer),
    .phase_a (s_axis_tdata[0]),
    .phase_b (s_axis_tdata[1]),
    .res     (step_res)
  );

  qdec_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_data (step_res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // pack result fields from the lowest bit up, pad to whole bytes
  assign m_axis_tdata = {3'b000, out_res.fault_kind, out_res.fault_flag,
                         out_res.moving_dir, out_res.position};

endmodule

[design/qdec_step.sv]
// ----------------------------------------------------------------------------
// qdec_step
// decoder state and its combinational update for one phase sample
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qdec_step import qdec_pkg::*; #(
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
  parameter int TOGGLE_WIDTH = TOGGLE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    push,
  input  logic    phase_a,
  input  logic    phase_b,
  output result_t res
);

  localparam int CMP_WIDTH = (TOGGLE_WIDTH > CFG_WIDTH) ? TOGGLE_WIDTH : CFG_WIDTH;

  logic [1:0]              prev_ab;
  logic [TOGGLE_WIDTH-1:0] toggles_a;
  logic [TOGGLE_WIDTH-1:0] toggles_b;
  logic [7:0]              bad_steps;
  logic [COUNT_WIDTH-1:0]  pulse_total;
  logic [1:0]              last_dir;
  fault_t                  fault_reason;

  logic [1:0]              new_ab;
  logic [1:0]              diff;
  step_t                   step;
  logic [TOGGLE_WIDTH-1:0] toggles_a_next;
  logic [TOGGLE_WIDTH-1:0] toggles_b_next;
  logic [7:0]              bad_steps_next;
  logic [COUNT_WIDTH-1:0]  pulse_total_next;
  logic [1:0]              last_dir_next;
  fault_t                  fault_reason_next;
  logic [CMP_WIDTH-1:0]    ta_cmp;
  logic [CMP_WIDTH-1:0]    tb_cmp;
  logic [CMP_WIDTH-1:0]    win_cmp;
  logic [CMP_WIDTH-1:0]    min_cmp;

  assign new_ab = {phase_a, phase_b};
  assign diff   = new_ab ^ prev_ab;
  assign step   = step_lookup(prev_ab, new_ab);

  always_comb begin
    toggles_a_next    = toggles_a;
    toggles_b_next    = toggles_b;
    bad_steps_next    = bad_steps;
    pulse_total_next  = pulse_total;
    last_dir_next     = last_dir;
    fault_reason_next = fault_reason;

    // saturating toggle counters
    if (diff[1] && !(&toggles_a)) begin
      toggles_a_next = toggles_a + {{(TOGGLE_WIDTH-1){1'b0}}, 1'b1};
    end
    if (diff[0] && !(&toggles_b)) begin
      toggles_b_next = toggles_b + {{(TOGGLE_WIDTH-1){1'b0}}, 1'b1};
    end

    case (step)
      STEP_BAD: begin
        if (!(&bad_steps)) begin
          bad_steps_next = bad_steps + 8'd1;
        end
        if (bad_steps_next >= cfg.error_limit) begin
          fault_reason_next = FAULT_INVALID;
        end
      end
      STEP_FWD: begin
        pulse_total_next  = pulse_total + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        last_dir_next     = DIR_FWD;
        fault_reason_next = FAULT_OK;
        bad_steps_next    = 8'd0;
      end
      STEP_REV: begin
        pulse_total_next  = pulse_total - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        last_dir_next     = DIR_REV;
        fault_reason_next = FAULT_OK;
        bad_steps_next    = 8'd0;
      end
      default: begin
      end
    endcase

    ta_cmp  = CMP_WIDTH'(toggles_a_next);
    tb_cmp  = CMP_WIDTH'(toggles_b_next);
    win_cmp = CMP_WIDTH'(cfg.check_window);
    min_cmp = CMP_WIDTH'(cfg.min_toggles);

    // phase health check
    if (ta_cmp >= win_cmp || tb_cmp >= win_cmp) begin
      if (ta_cmp < min_cmp) begin
        fault_reason_next = FAULT_A_DEAD;
      end else if (tb_cmp < min_cmp) begin
        fault_reason_next = FAULT_B_DEAD;
      end else if (fault_reason_next != FAULT_INVALID) begin
        fault_reason_next = FAULT_OK;
        toggles_a_next    = '0;
        toggles_b_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab      <= 2'b00;
      toggles_a    <= '0;
      toggles_b    <= '0;
      bad_steps    <= 8'd0;
      pulse_total  <= '0;
      last_dir     <= DIR_NONE;
      fault_reason <= FAULT_OK;
    end else if (push) begin
      prev_ab      <= new_ab;
      toggles_a    <= toggles_a_next;
      toggles_b    <= toggles_b_next;
      bad_steps    <= bad_steps_next;
      pulse_total  <= pulse_total_next;
      last_dir     <= last_dir_next;
      fault_reason <= fault_reason_next;
    end
  end

  // position is the pulse total sign-extended or cut to the port width
  generate
    if (COUNT_WIDTH >= POS_WIDTH) begin : g_pos_cut
      assign res.position = pulse_total_next[POS_WIDTH-1:0];
    end else begin : g_pos_ext
      assign res.position = {{(POS_WIDTH-COUNT_WIDTH){pulse_total_next[COUNT_WIDTH-1]}},
                             pulse_total_next};
    end
  endgenerate

  assign res.moving_dir = last_dir_next;
  assign res.fault_flag = (fault_reason_next != FAULT_OK);
  assign res.fault_kind = fault_reason_next;

  `QD_ASSERT(a_step_clears_bad, clk, rst,
    push && (step == STEP_FWD || step == STEP_REV) |=> bad_steps == 8'd0,
    "valid step left the error count set")
  `QD_ASSERT(a_still_holds_pos, clk, rst,
    push && (step == STEP_NONE || step == STEP_BAD) |=> $stable(pulse_total),
    "pulse total moved without a valid step")
  `QD_ASSERT(a_idle_holds_state, clk, rst,
    !push |=> $stable(prev_ab) && $stable(fault_reason),
    "decoder state changed with no sample")

endmodule

[design/qdec_obuf.sv]
// ----------------------------------------------------------------------------
// qdec_obuf
// result register with one skid entry between decoder and output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qdec_obuf import qdec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= push;
        skid_data  <= push_data;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  `QD_ASSERT(a_skid_behind_head, clk, rst, !skid_valid || out_valid,
    "skid entry held with empty output register")
  `QD_ASSERT(a_no_overflow, clk, rst, push |-> !skid_valid,
    "result pushed into a full buffer")
  `QD_ASSERT(a_fill_counts, clk, rst,
    push && !pop && out_valid |=> skid_valid,
    "result lost while output stalled")

endmodule
